// ===== src/sha_pkg.sv =====
// Package: shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

  localparam int unsigned QueueDepthDef = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenSlot  = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/sha_queue.sv =====
// Small FIFO between the input front end and the hashing engine.
module sha_queue import sha_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  sha_in_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output sha_in_t rd_data,
  output logic    empty
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_in_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW+1)'(Depth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd_en && !empty) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end
endmodule

// ===== src/sha_engine.sv =====
// Hashing engine: byte packing, padding, 64-round compression and digest emission.
module sha_engine import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  sha_in_t  q_data,
  output logic     q_pop,
  output logic     out_empty,
  output sha_out_t out_data,
  input  logic     out_pop
);
  sha_state_t  state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [60:0] cnt_r;
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        fin_r;
  logic        second_r;
  logic        padded_r;

  logic [5:0]  pos;
  logic [31:0] s0, s1, t1, t2, wnew, sg0, sg1;
  logic [63:0] bits;

  assign pos   = cnt_r[5:0];
  assign bits  = {cnt_r, 3'b000};
  assign s1    = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
  assign s0    = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
  assign t1    = v_r[7] + s1 + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + K[rnd_r] + w_r[0];
  assign t2    = s0 + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign sg0   = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
  assign sg1   = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew  = w_r[0] + sg0 + w_r[9] + sg1;

  assign out_empty = (state_r != ST_EMIT);
  assign out_data  = '{digest_word: h_r[idx_r], word_index: idx_r,
                       last_word: (idx_r == 3'd7)};

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.has_byte && pos == 6'd63) state_nxt = ST_ROUND;
          else if (q_data.end_of_message) state_nxt = ST_PAD;
        end
      end
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (fin_r && second_r) state_nxt = ST_EMIT;
        else if (fin_r) state_nxt = ST_PAD;
        else state_nxt = ST_IDLE;
      end
      ST_PAD: state_nxt = ST_ROUND;
      ST_EMIT: if (out_pop && idx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= IV[i];
        v_r[i] <= '0;
      end
      cnt_r    <= '0;
      rnd_r    <= '0;
      idx_r    <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      padded_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            fin_r    <= q_data.end_of_message;
            second_r <= 1'b0;
            rnd_r    <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            if (q_data.has_byte) begin
              cnt_r <= cnt_r + 61'd1;
              if (pos[1:0] == 2'd0) w_r[pos[5:2]] <= {q_data.data_byte, 24'd0};
              else w_r[pos[5:2]] <= w_r[pos[5:2]] |
                   (32'(q_data.data_byte) << (5'(3 - pos[1:0]) * 5'd8));
            end
          end
        end
        ST_ROUND: begin
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          rnd_r <= rnd_r + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
            v_r[i] <= h_r[i] + v_r[i];
          end
          idx_r <= '0;
        end
        ST_PAD: begin
          rnd_r <= '0;
          if (!padded_r) begin
            padded_r <= 1'b1;
            for (int i = 0; i < 16; i++) begin
              if (i == int'(pos[5:2])) begin
                if (pos[1:0] == 2'd0) w_r[i] <= {PadByte, 24'd0};
                else w_r[i] <= w_r[i] | (32'(PadByte) << (5'(3 - pos[1:0]) * 5'd8));
              end else if (i > int'(pos[5:2])) w_r[i] <= '0;
            end
            if (pos < LenSlot) begin
              second_r <= 1'b1;
              w_r[14]  <= bits[63:32];
              w_r[15]  <= bits[31:0];
            end
          end else begin
            second_r <= 1'b1;
            for (int i = 0; i < 14; i++) w_r[i] <= '0;
            w_r[14] <= bits[63:32];
            w_r[15] <= bits[31:0];
          end
        end
        ST_EMIT: begin
          if (out_pop) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
              cnt_r    <= '0;
              fin_r    <= 1'b0;
              second_r <= 1'b0;
              padded_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/sha256_stream_hasher_top.sv =====
// Top level of the SHA-256 stream hasher: input queue and hashing engine.
// Each byte is popped from the queue into the message schedule; a byte completing a 64-byte
// block starts a compression (load, 64 rounds on one shared round unit, then chaining add).
// End of message adds one or two padding blocks, then 8 digest transfers.
// The input queue (QueueDepth entries, 4 by default) lets pushes continue while the engine compresses.
// Reset (rst_n low, synchronous) loads the initial hash values and clears the count.
module sha256_stream_hasher_top import sha_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  sha_in_t  in_data,
  output logic     in_full,
  input  logic     out_pop,
  output logic     out_empty,
  output sha_out_t out_data
);
  logic    q_empty, q_pop;
  sha_in_t q_data;

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .wr_en(in_push), .wr_data(in_data), .full(in_full),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty));

  sha_engine u_engine (
    .clk, .rst_n, .q_empty, .q_data, .q_pop, .out_empty, .out_data, .out_pop);
endmodule
